// File: rtl/assert_macros.svh
// Assertion macros shared by the held key tracker RTL.
// Needs a clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define HKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define HKT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/hkt_pkg.sv
// Package for the held key tracker: sizes, payload structs, codes and
// the command/status structs between controller and datapath. No dependencies.
`default_nettype none

package hkt_pkg;

  localparam int TRACK_DEPTH   = 6;
  localparam int SHOWN_ENTRIES = 3;

  localparam int IDX_W  = (TRACK_DEPTH > 1) ? $clog2(TRACK_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TRACK_DEPTH + 1);
  localparam int SLOT_W = (SHOWN_ENTRIES > 1) ? $clog2(SHOWN_ENTRIES) : 1;

  localparam logic ACT_RELEASE = 1'b0;
  localparam logic ACT_PRESS   = 1'b1;

  typedef enum logic [1:0] {
    KIND_HELD     = 2'd0,
    KIND_RELEASED = 2'd1,
    KIND_IDLE     = 2'd2
  } kind_t;

  typedef struct packed {
    logic        action;
    logic [15:0] hid_page;
    logic [15:0] key_code;
    logic [7:0]  implicit_mods;
    logic [7:0]  explicit_mods;
    logic [31:0] event_time;
  } hkt_in_t;

  typedef struct packed {
    kind_t       kind;
    logic [2:0]  held_total;
    logic        more_held;
    logic [1:0]  slot;
    logic [15:0] out_page;
    logic [15:0] out_code;
    logic [7:0]  out_implicit_mods;
    logic [7:0]  out_explicit_mods;
    logic [31:0] hold_duration;
    logic        last_of_run;
  } hkt_out_t;

  typedef struct packed {
    logic              cap_in;
    logic              find;
    logic              apply;
    logic              emit;
    logic [SLOT_W-1:0] slot;
  } hkt_cmd_t;

  typedef struct packed {
    logic emit_last;
  } hkt_status_t;

endpackage

`default_nettype wire

// File: rtl/hkt_ctrl.sv
// Controller of the held key tracker: sequences capture, lookup, table update
// and snapshot emission. Uses hkt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hkt_ctrl
  import hkt_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  output hkt_cmd_t         cmd,
  input  wire hkt_status_t status
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FIND  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t            state_r, state_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;

  always_comb begin
    state_nxt = state_r;
    slot_nxt  = slot_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_FIND;
        end
      end
      ST_FIND:  state_nxt = ST_APPLY;
      ST_APPLY: begin
        state_nxt = ST_EMIT;
        slot_nxt  = '0;
      end
      ST_EMIT: begin
        if (status.emit_last) begin
          state_nxt = ST_IDLE;
          slot_nxt  = '0;
        end else begin
          slot_nxt = slot_r + SLOT_W'(1);
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      slot_r  <= '0;
    end else begin
      state_r <= state_nxt;
      slot_r  <= slot_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign cmd.cap_in = (state_r == ST_IDLE) && start;
  assign cmd.find   = (state_r == ST_FIND);
  assign cmd.apply  = (state_r == ST_APPLY);
  assign cmd.emit   = (state_r == ST_EMIT);
  assign cmd.slot   = slot_r;

  `HKT_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy, "accepted event did not raise busy")
  `HKT_ASSERT(a_emit_follows_apply, cmd.apply |=> cmd.emit, "table update not followed by emission")
  `HKT_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !busy, "busy after reset")

endmodule

`default_nettype wire

// File: rtl/hkt_datapath.sv
// Datapath of the held key tracker: held key table, release record, lookup
// and the registered result stage. Uses hkt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module hkt_datapath
  import hkt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire hkt_cmd_t cmd,
  input  wire hkt_in_t  in_item,
  output hkt_status_t   status,
  output logic          out_valid,
  output hkt_out_t      out_item
);

  hkt_in_t     in_r;
  logic [31:0] in_key;
  logic [15:0] in_mods;

  logic [31:0] key_r   [TRACK_DEPTH];
  logic [15:0] mods_r  [TRACK_DEPTH];
  logic [31:0] press_r [TRACK_DEPTH];
  logic [31:0] key_nxt   [TRACK_DEPTH];
  logic [15:0] mods_nxt  [TRACK_DEPTH];
  logic [31:0] press_nxt [TRACK_DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;

  logic        hit_r, hit;
  logic [IDX_W-1:0] idx_r, idx;

  logic        rel_valid_r, rel_valid_nxt;
  logic [31:0] rel_key_r, rel_key_nxt;
  logic [15:0] rel_mods_r, rel_mods_nxt;
  logic [31:0] rel_dur_r, rel_dur_nxt;

  logic [IDX_W-1:0] rd_idx;
  logic [31:0]      rd_key;
  logic [15:0]      rd_mods;
  logic [31:0]      rd_press;

  logic [CNT_W-1:0] shown;
  logic             emit_last;

  hkt_out_t out_r, out_nxt;
  logic     out_valid_r;

  assign in_key  = {in_r.hid_page, in_r.key_code};
  assign in_mods = {in_r.implicit_mods, in_r.explicit_mods};

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_r <= in_item;
    end
  end

  // Lowest matching live entry wins.
  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = TRACK_DEPTH - 1; i >= 0; i--) begin
      if ((CNT_W'(i) < count_r) && (key_r[i] == in_key)) begin
        hit = 1'b1;
        idx = IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.find) begin
      hit_r <= hit;
      idx_r <= idx;
    end
  end

  // Single read port: the matched entry during update, the slot during emission.
  assign rd_idx   = cmd.apply ? idx_r : IDX_W'(cmd.slot);
  assign rd_key   = key_r[rd_idx];
  assign rd_mods  = mods_r[rd_idx];
  assign rd_press = press_r[rd_idx];

  always_comb begin
    for (int i = 0; i < TRACK_DEPTH; i++) begin
      key_nxt[i]   = key_r[i];
      mods_nxt[i]  = mods_r[i];
      press_nxt[i] = press_r[i];
    end
    count_nxt     = count_r;
    rel_valid_nxt = rel_valid_r;
    rel_key_nxt   = rel_key_r;
    rel_mods_nxt  = rel_mods_r;
    rel_dur_nxt   = rel_dur_r;
    if (cmd.apply) begin
      if ((in_r.action == ACT_PRESS) && !hit_r) begin
        if (count_r == CNT_W'(TRACK_DEPTH)) begin
          // Full: drop the oldest and append at the top.
          for (int i = 0; i < TRACK_DEPTH - 1; i++) begin
            key_nxt[i]   = key_r[i + 1];
            mods_nxt[i]  = mods_r[i + 1];
            press_nxt[i] = press_r[i + 1];
          end
          key_nxt[TRACK_DEPTH - 1]   = in_key;
          mods_nxt[TRACK_DEPTH - 1]  = in_mods;
          press_nxt[TRACK_DEPTH - 1] = in_r.event_time;
        end else begin
          for (int i = 0; i < TRACK_DEPTH; i++) begin
            if (CNT_W'(i) == count_r) begin
              key_nxt[i]   = in_key;
              mods_nxt[i]  = in_mods;
              press_nxt[i] = in_r.event_time;
            end
          end
          count_nxt = count_r + CNT_W'(1);
        end
      end else if ((in_r.action == ACT_RELEASE) && hit_r) begin
        // Close the gap above the released entry.
        for (int i = 0; i < TRACK_DEPTH - 1; i++) begin
          if (IDX_W'(i) >= idx_r) begin
            key_nxt[i]   = key_r[i + 1];
            mods_nxt[i]  = mods_r[i + 1];
            press_nxt[i] = press_r[i + 1];
          end
        end
        count_nxt = count_r - CNT_W'(1);
        if (count_r == CNT_W'(1)) begin
          rel_valid_nxt = 1'b1;
          rel_key_nxt   = rd_key;
          rel_mods_nxt  = rd_mods;
          rel_dur_nxt   = in_r.event_time - rd_press;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < TRACK_DEPTH; i++) begin
      key_r[i]   <= key_nxt[i];
      mods_r[i]  <= mods_nxt[i];
      press_r[i] <= press_nxt[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rel_valid_r <= 1'b0;
      rel_key_r   <= '0;
      rel_mods_r  <= '0;
      rel_dur_r   <= '0;
    end else begin
      count_r     <= count_nxt;
      rel_valid_r <= rel_valid_nxt;
      rel_key_r   <= rel_key_nxt;
      rel_mods_r  <= rel_mods_nxt;
      rel_dur_r   <= rel_dur_nxt;
    end
  end

  assign shown     = (count_r > CNT_W'(SHOWN_ENTRIES)) ? CNT_W'(SHOWN_ENTRIES) : count_r;
  assign emit_last = (count_r == '0) || ((CNT_W'(cmd.slot) + CNT_W'(1)) == shown);
  assign status.emit_last = emit_last;

  always_comb begin
    out_nxt = '0;
    out_nxt.last_of_run = emit_last;
    priority if (count_r != '0) begin
      out_nxt.kind              = KIND_HELD;
      out_nxt.held_total        = 3'(count_r);
      out_nxt.more_held         = (count_r > CNT_W'(SHOWN_ENTRIES));
      out_nxt.slot              = 2'(cmd.slot);
      out_nxt.out_page          = rd_key[31:16];
      out_nxt.out_code          = rd_key[15:0];
      out_nxt.out_implicit_mods = rd_mods[15:8];
      out_nxt.out_explicit_mods = rd_mods[7:0];
    end else if (rel_valid_r) begin
      out_nxt.kind              = KIND_RELEASED;
      out_nxt.out_page          = rel_key_r[31:16];
      out_nxt.out_code          = rel_key_r[15:0];
      out_nxt.out_implicit_mods = rel_mods_r[15:8];
      out_nxt.out_explicit_mods = rel_mods_r[7:0];
      out_nxt.hold_duration     = rel_dur_r;
    end else begin
      out_nxt.kind = KIND_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  `HKT_ASSERT(a_count_bound, count_r <= CNT_W'(TRACK_DEPTH), "held count beyond table depth")
  `HKT_ASSERT(a_non_held_single, (out_valid && (out_item.kind != KIND_HELD)) |-> out_item.last_of_run, "release or idle snapshot not final")
  `HKT_ASSERT(a_release_kept, $past(rel_valid_r) |-> rel_valid_r, "release record lost")

endmodule

`default_nettype wire

// File: rtl/held_key_tracker_unit.sv
// Top level of the held key tracker: controller plus datapath.
// Uses hkt_pkg, hkt_ctrl and hkt_datapath.
//
//   channel  handshake         payload
//   input    start / busy      in_item  (hkt_in_t)
//   result   out_valid strobe  out_item (hkt_out_t)
//
// An event runs through capture, lookup and table update, then one emission
// step per result item, one to SHOWN_ENTRIES items, set by the controller sequence
// and the single table read port shared by the update and the emission.
// Each result appears in the cycle after its emission step, for one cycle.
// Synchronous active-low reset empties the table and clears the release record.
// Results cannot be stalled; busy drops as the final result is registered.
`default_nettype none

module held_key_tracker_unit
  import hkt_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire hkt_in_t in_item,
  output logic         out_valid,
  output hkt_out_t     out_item
);

  hkt_cmd_t    cmd;
  hkt_status_t status;

  hkt_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .cmd    (cmd),
    .status (status)
  );

  hkt_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
